// ===== src/mtma_pkg.sv =====
// ----------------------------------------------------------------------------
// mtma_pkg: shared types and constants
// Data width of the distance channels and the sequencer states.
// ----------------------------------------------------------------------------
package mtma_pkg;

  localparam int DATA_W = 16;

  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    ST_IDLE,     // waiting for a sample beat
    ST_LOAD,     // fetch the next median candidate
    ST_SCAN,     // rank the candidate, one compare per cycle
    ST_AVG_SUB,  // drop the oldest median from the running total once full
    ST_AVG_ADD,  // add the new median, start the divider
    ST_DIV,      // restoring divide, one quotient bit per cycle
    ST_FINISH    // hand the result to the output register
  } mtma_state_t;

endpackage

// ===== src/mtma_dist_if.sv =====
// ----------------------------------------------------------------------------
// mtma_dist_if: raw distance stream
// Valid/ready channel carrying one raw distance sample per beat.
// ----------------------------------------------------------------------------
interface mtma_dist_if;
  import mtma_pkg::*;

  logic  valid;
  logic  ready;
  data_t distance;

  modport source (output valid, output distance, input ready);
  modport sink   (input valid, input distance, output ready);
endinterface

// ===== src/mtma_filt_if.sv =====
// ----------------------------------------------------------------------------
// mtma_filt_if: filtered distance stream
// Valid/ready channel carrying one filtered distance per beat.
// ----------------------------------------------------------------------------
interface mtma_filt_if;
  import mtma_pkg::*;

  logic  valid;
  logic  ready;
  data_t smoothed;

  modport source (output valid, output smoothed, input ready);
  modport sink   (input valid, input smoothed, output ready);
endinterface

// ===== src/median_then_moving_average_filter.sv =====
// ----------------------------------------------------------------------------
// median_then_moving_average_filter: running median + moving average
// Upper median over a circular sample window, then a moving average over the
// last medians, divided down by a bit-serial divider.
// ----------------------------------------------------------------------------
//
//  channel    dir   beat payload                 notes
//  ---------  ----  ---------------------------  -----------------------------
//  sample     in    distance [15:0]              ready only while idle
//  filtered   out   smoothed [15:0]              output register
//  cfg        in    cfg_wr_data = filter_on      write of 1 restarts median
//
//  Per item (filter on): LOAD and SCAN for each of t <= n candidates tried by
//  the ranking loop, with n the median fill (one comparator, one compare per
//  cycle), then AVG_SUB, AVG_ADD, SUM_W = 19 divider steps (default), FINISH.
//  Filter off: IDLE goes straight to FINISH, the sample is returned as is.
//  Reset: synchronous; clears fills, positions, total, filter_on = 1.
//  A result waiting in the output register does not block the next sample;
//  the sequencer only stalls in FINISH until the output register is free.
//
module median_then_moving_average_filter #(
  parameter int MEDIAN_TAPS  = 5,
  parameter int AVERAGE_TAPS = 8
) (
  input  logic        clk,
  input  logic        rst,
  mtma_dist_if.sink   sample,
  mtma_filt_if.source filtered,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);
  import mtma_pkg::*;

  // widths
  localparam int MI_W  = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
  localparam int MF_W  = $clog2(MEDIAN_TAPS + 1);
  localparam int AI_W  = (AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 1;
  localparam int AF_W  = $clog2(AVERAGE_TAPS + 1);
  localparam int SUM_W = DATA_W + ((AVERAGE_TAPS > 1) ? $clog2(AVERAGE_TAPS) : 0);
  localparam int DC_W  = $clog2(SUM_W);

  mtma_state_t state, state_next;

  logic filter_on;

  // median window, one read port at rd_idx
  data_t            med_win [MEDIAN_TAPS];
  logic [MI_W-1:0]  med_wpos;
  logic [MF_W-1:0]  med_fill;
  logic [MF_W-1:0]  med_n;
  logic [MI_W-1:0]  med_i;
  logic [MI_W-1:0]  med_j;
  logic [MF_W-1:0]  med_lt;
  logic [MF_W-1:0]  med_le;
  data_t            med_cand;
  data_t            med_val;

  // average window
  data_t            avg_win [AVERAGE_TAPS];
  logic [AI_W-1:0]  avg_wpos;
  logic [AF_W-1:0]  avg_fill;
  logic [SUM_W-1:0] avg_total;

  // divider
  logic [SUM_W-1:0] div_q;
  logic [AF_W-1:0]  div_rem;
  logic [DC_W-1:0]  div_cnt;

  data_t result;
  logic  out_valid;
  data_t out_data;

  // ranking step: count entries below / not above the candidate
  logic [MI_W-1:0]  rd_idx;
  data_t            rd_data;
  logic [MF_W-1:0]  lt_n, le_n, med_k;
  logic             scan_last, scan_hit;
  logic [SUM_W-1:0] avg_total_add;
  logic [AF_W:0]    rem_sh;
  logic             rem_ge;
  logic [SUM_W-1:0] div_q_next;
  logic             sample_acc, out_free;

  assign rd_idx    = (state == ST_LOAD) ? med_i : med_j;
  assign rd_data   = med_win[rd_idx];
  assign lt_n      = med_lt + MF_W'(rd_data <  med_cand);
  assign le_n      = med_le + MF_W'(rd_data <= med_cand);
  assign med_k     = med_n >> 1;
  assign scan_last = (MF_W'(med_j) == med_n - MF_W'(1));
  assign scan_hit  = (lt_n <= med_k) && (med_k < le_n);

  assign avg_total_add = avg_total + SUM_W'(med_val);

  // restoring divide step; remainder stays below the divisor
  assign rem_sh     = {div_rem, div_q[SUM_W-1]};
  assign rem_ge     = (rem_sh >= {1'b0, avg_fill});
  assign div_q_next = {div_q[SUM_W-2:0], rem_ge};

  assign sample_acc = sample.valid && sample.ready;
  assign out_free   = !out_valid || filtered.ready;

  assign sample.ready      = (state == ST_IDLE);
  assign filtered.valid    = out_valid;
  assign filtered.smoothed = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (sample_acc) begin
          state_next = filter_on ? ST_LOAD : ST_FINISH;
        end
      end
      ST_LOAD:    state_next = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) begin
          state_next = scan_hit ? ST_AVG_SUB : ST_LOAD;
        end
      end
      ST_AVG_SUB: state_next = ST_AVG_ADD;
      ST_AVG_ADD: state_next = ST_DIV;
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_on <= 1'b1;
      med_wpos  <= '0;
      med_fill  <= '0;
      avg_wpos  <= '0;
      avg_fill  <= '0;
      avg_total <= '0;
      out_valid <= 1'b0;
    end else begin
      if (filtered.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (sample_acc && filter_on) begin
            med_wpos <= (med_wpos == MI_W'(MEDIAN_TAPS - 1)) ? '0 : med_wpos + MI_W'(1);
            if (med_fill != MF_W'(MEDIAN_TAPS)) begin
              med_fill <= med_fill + MF_W'(1);
            end
          end
        end
        ST_AVG_SUB: begin
          if (avg_fill == AF_W'(AVERAGE_TAPS)) begin
            avg_total <= avg_total - SUM_W'(avg_win[avg_wpos]);
          end else begin
            avg_fill <= avg_fill + AF_W'(1);
          end
        end
        ST_AVG_ADD: begin
          avg_total <= avg_total_add;
          avg_wpos  <= (avg_wpos == AI_W'(AVERAGE_TAPS - 1)) ? '0 : avg_wpos + AI_W'(1);
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
          end
        end
        default: ;
      endcase
      // writing 1 restarts the median window; the average window stays
      if (cfg_wr_en) begin
        filter_on <= cfg_wr_data;
        if (cfg_wr_data) begin
          med_fill <= '0;
          med_wpos <= '0;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (sample_acc) begin
          result <= sample.distance;
          if (filter_on) begin
            med_win[med_wpos] <= sample.distance;
            med_n <= (med_fill != MF_W'(MEDIAN_TAPS)) ? med_fill + MF_W'(1) : med_fill;
            med_i <= '0;
          end
        end
      end
      ST_LOAD: begin
        med_cand <= rd_data;
        med_j    <= '0;
        med_lt   <= '0;
        med_le   <= '0;
      end
      ST_SCAN: begin
        med_lt <= lt_n;
        med_le <= le_n;
        med_j  <= med_j + MI_W'(1);
        if (scan_last) begin
          med_i   <= med_i + MI_W'(1);
          med_val <= med_cand;
        end
      end
      ST_AVG_ADD: begin
        avg_win[avg_wpos] <= med_val;
        div_q   <= avg_total_add;
        div_rem <= '0;
        div_cnt <= DC_W'(SUM_W - 1);
      end
      ST_DIV: begin
        div_q   <= div_q_next;
        div_rem <= rem_ge ? AF_W'(rem_sh - {1'b0, avg_fill}) : AF_W'(rem_sh);
        div_cnt <= div_cnt - DC_W'(1);
        if (div_cnt == '0) begin
          result <= div_q_next[DATA_W-1:0];
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_data <= result;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_med_fill_range: assert property (@(posedge clk) disable iff (rst)
    med_fill <= MF_W'(MEDIAN_TAPS))
    else $error("median fill beyond window depth");

  a_avg_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (avg_fill != '0 && avg_fill <= AF_W'(AVERAGE_TAPS)))
    else $error("divide by empty or overfull average window");

  a_rank_found: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && scan_last && !scan_hit) |-> (MF_W'(med_i) != med_n - MF_W'(1)))
    else $error("median search ran out of candidates");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("finished result not presented");

endmodule
